[design/bfm_pkg.sv]
// Shared types and constants for the Bloom filter membership block.
// No dependencies; used by the top level, the checker and the testbench.
package bfm_pkg;

  localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;   // prime = 2^40 + 0x1B3
  localparam logic [31:0] GOLDEN_STEP = 32'h9E3779B1;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  localparam int          CFG_IDX_W       = 8;
  localparam int          CFG_DATA_W      = 32;
  localparam logic [7:0]  REG_PROBE_COUNT = 8'd0;
  localparam logic [7:0]  REG_ACTIVE_BITS = 8'd1;
  localparam logic [4:0]  PROBE_COUNT_RST = 5'd4;
  localparam logic [16:0] ACTIVE_BITS_RST = 17'd65536;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key_byte;
    logic       has_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic        maybe_present;
    logic [16:0] set_bits;
    logic [1:0]  done_kind;
  } out_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV1  = 6'b000100,
    ST_DIV2  = 6'b001000,
    ST_READ  = 6'b010000,
    ST_EVAL  = 6'b100000
  } state_t;

endpackage

[design/bfm_mod_unit.sv]
// Iterative 32-bit by N-bit remainder unit, one quotient bit per cycle.
// Depends on nothing but its parameter; used by the top level.
module bfm_mod_unit #(
  parameter int MW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [MW-1:0] divisor,
  output logic          done,
  output logic [MW-1:0] rem
);

  logic [31:0]   dvd_r, dvd_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] div_r, div_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [MW:0]   trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[31]};
    if (start) begin
      dvd_nxt = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = MW'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[MW-1:0];
      end
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[design/bloom_filter_membership_top.sv]
// Top level of the Bloom filter membership block: FNV-1a hashing, probe
// sequencer and the bit store. Depends on bfm_pkg and bfm_mod_unit.
//
// Usage: key bytes arrive as items on in_item, accepted when start is high
// and busy is low. A non-last byte is folded into the hash and gives no
// result. The last byte of an add or query starts probing: two remainders
// (h1 and h2 modulo active_bits, clamped to 1..MAX_BITS) from the shared
// bit-serial unit, then per probe a read state and an eval state for the
// memory read and update. The next item can be taken in the cycle in which
// the result appears. A clear item sweeps the store one bit a cycle over all
// MAX_BITS bits, then gives its result. Each result appears on out_item for
// one cycle with out_valid high; the receiver cannot stall, so nothing
// waits. Configuration writes on the cfg_ channel are always taken
// (cfg_ready is high) and are meant for idle times. After reset the store is
// cleared by the same sweep, with busy high, and no result is given for it.
module bloom_filter_membership_top #(
  parameter int MAX_BITS   = 65536,
  parameter int MAX_PROBES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  bfm_pkg::in_t                    in_item,
  output logic                            out_valid,
  output bfm_pkg::out_t                   out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int MW = $clog2(MAX_BITS + 1);
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BITS - 1);

  bfm_pkg::state_t state_r, state_nxt;

  logic [4:0]    probe_count_r;
  logic [16:0]   active_bits_r;
  logic [63:0]   hash_r, hash_nxt;
  logic [63:0]   hash_x, hash_new;
  logic [MW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   h2_r, h2_nxt;
  logic [31:0]   h1_nxt;
  logic [1:0]    func_r, func_nxt;
  logic [MW-1:0] mod_r, mod_nxt;
  logic [PW-1:0] n_r, n_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [MW-1:0] pos_r, pos_nxt;
  logic [MW-1:0] step_r, step_nxt;
  logic [MW:0]   pos_sum;
  logic          all_set_r, all_set_nxt;
  logic          clr_item_r, clr_item_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  bfm_pkg::out_t out_r, out_nxt;
  logic [31:0]   eff_mod, eff_n;

  logic          div_start, div_done;
  logic [31:0]   div_dividend;
  logic [MW-1:0] div_rem;

  logic          mem [MAX_BITS];
  logic          rd_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;

  logic accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != bfm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // FNV-1a step; the prime is 2^40 + 0x1B3, so one shift and a narrow multiply.
  assign hash_x   = hash_r ^ {56'd0, in_item.key_byte};
  assign hash_new = (hash_x << 40) + (hash_x * {55'd0, bfm_pkg::FNV_PRIME_LO});

  always_comb begin
    eff_mod = 32'(active_bits_r);
    if (eff_mod == 32'd0) begin
      eff_mod = 32'd1;
    end else if (eff_mod > 32'(MAX_BITS)) begin
      eff_mod = 32'(MAX_BITS);
    end
    eff_n = 32'(probe_count_r);
    if (eff_n == 32'd0) begin
      eff_n = 32'd1;
    end else if (eff_n > 32'(MAX_PROBES)) begin
      eff_n = 32'(MAX_PROBES);
    end
  end

  // The divisor is taken from the next-value side so the first division
  // of a key already sees the modulus latched with it.
  bfm_mod_unit #(.MW(MW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (mod_nxt),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign pos_sum  = {1'b0, pos_r} + {1'b0, step_r};

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    cnt_nxt       = cnt_r;
    h2_nxt        = h2_r;
    h1_nxt        = hash_r[31:0];
    func_nxt      = func_r;
    mod_nxt       = mod_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    all_set_nxt   = all_set_r;
    clr_item_nxt  = clr_item_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_start     = 1'b0;
    div_dividend  = h2_r;
    mem_we        = 1'b0;
    mem_addr      = pos_r[AW-1:0];

    case (state_r)
      bfm_pkg::ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = bfm_pkg::ST_IDLE;
          cnt_nxt   = '0;
          if (clr_item_r) begin
            out_valid_nxt     = 1'b1;
            out_nxt.maybe_present = 1'b0;
            out_nxt.set_bits  = 17'd0;
            out_nxt.done_kind = bfm_pkg::FUNC_CLEAR;
          end
          clr_item_nxt = 1'b0;
        end
      end
      bfm_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item.func)
            bfm_pkg::FUNC_ADD, bfm_pkg::FUNC_QUERY: begin
              h1_nxt = in_item.has_byte ? hash_new[31:0] : hash_r[31:0];
              if (in_item.has_byte) begin
                hash_nxt = hash_new;
              end
              if (in_item.last) begin
                h2_nxt = in_item.has_byte ? hash_new[63:32] : hash_r[63:32];
                if (h2_nxt == 32'd0) begin
                  h2_nxt = bfm_pkg::GOLDEN_STEP;
                end
                hash_nxt     = bfm_pkg::FNV_BASIS;
                func_nxt     = in_item.func;
                mod_nxt      = MW'(eff_mod);
                n_nxt        = PW'(eff_n);
                div_start    = 1'b1;
                div_dividend = h1_nxt;
                state_nxt    = bfm_pkg::ST_DIV1;
              end
            end
            bfm_pkg::FUNC_CLEAR: begin
              hash_nxt     = bfm_pkg::FNV_BASIS;
              clr_item_nxt = 1'b1;
              clr_addr_nxt = '0;
              state_nxt    = bfm_pkg::ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      bfm_pkg::ST_DIV1: begin
        if (div_done) begin
          pos_nxt      = div_rem;
          div_start    = 1'b1;
          div_dividend = h2_r;
          state_nxt    = bfm_pkg::ST_DIV2;
        end
      end
      bfm_pkg::ST_DIV2: begin
        if (div_done) begin
          step_nxt    = div_rem;
          idx_nxt     = '0;
          all_set_nxt = 1'b1;
          state_nxt   = bfm_pkg::ST_READ;
        end
      end
      bfm_pkg::ST_READ: begin
        state_nxt = bfm_pkg::ST_EVAL;
      end
      bfm_pkg::ST_EVAL: begin
        if (!rd_r) begin
          if (func_r == bfm_pkg::FUNC_ADD) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + MW'(1);
          end else begin
            all_set_nxt = 1'b0;
          end
        end
        // Positions stay below the modulus, so one subtract keeps the sum reduced.
        if (pos_sum >= {1'b0, mod_r}) begin
          pos_nxt = MW'(pos_sum - {1'b0, mod_r});
        end else begin
          pos_nxt = pos_sum[MW-1:0];
        end
        idx_nxt = idx_r + PW'(1);
        if (idx_r == n_r - PW'(1)) begin
          state_nxt     = bfm_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt.maybe_present = (func_r == bfm_pkg::FUNC_QUERY) && all_set_nxt;
          out_nxt.set_bits  = 17'(32'(cnt_nxt));
          out_nxt.done_kind = func_r;
        end else begin
          state_nxt = bfm_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = bfm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= (state_r == bfm_pkg::ST_EVAL);
    end
    rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bfm_pkg::ST_CLEAR;
      clr_addr_r    <= '0;
      clr_item_r    <= 1'b0;
      hash_r        <= bfm_pkg::FNV_BASIS;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      probe_count_r <= bfm_pkg::PROBE_COUNT_RST;
      active_bits_r <= bfm_pkg::ACTIVE_BITS_RST;
      idx_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_item_r  <= clr_item_nxt;
      hash_r      <= hash_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bfm_pkg::REG_PROBE_COUNT) begin
          probe_count_r <= cfg_data[4:0];
        end else if (cfg_index == bfm_pkg::REG_ACTIVE_BITS) begin
          active_bits_r <= cfg_data[16:0];
        end
      end
    end
    h2_r      <= h2_nxt;
    func_r    <= func_nxt;
    mod_r     <= mod_nxt;
    n_r       <= n_nxt;
    pos_r     <= pos_nxt;
    step_r    <= step_nxt;
    all_set_r <= all_set_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[design/bfm_checker.sv]
// Port-level checker for the Bloom filter membership block, bound to the top.
// Depends on bfm_pkg and bloom_filter_membership_top.
module bfm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input bfm_pkg::in_t  in_item,
  input logic          out_valid,
  input bfm_pkg::out_t out_item
);

  // The store is swept after reset, so the block stays busy.
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.func == bfm_pkg::FUNC_CLEAR |=> busy)
    else $error("clear item did not start a sweep");

  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.done_kind != bfm_pkg::FUNC_NONE)
    else $error("result with unused kind");

  a_answer_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.done_kind != bfm_pkg::FUNC_QUERY |-> !out_item.maybe_present)
    else $error("membership answer on add or clear");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.done_kind == bfm_pkg::FUNC_CLEAR |-> out_item.set_bits == 17'd0)
    else $error("clear left bits counted");

endmodule

bind bloom_filter_membership_top bfm_checker u_bfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

[test/tb.sv]
// Self-checking testbench for bloom_filter_membership_top.
// Needs bfm_pkg and the block's RTL. Directed items come first, then random
// keys under several probe-count and store-size settings, all checked.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STORE_BITS = 65536;
  localparam int          PROBE_MAX  = 16;
  localparam logic [63:0] FNV_MULT   = 64'h0000_0100_0000_01B3;
  localparam int          CYCLE_LIMIT = 3_000_000;

  typedef struct {
    bfm_pkg::in_t  item;
    bit            typed;
    bfm_pkg::out_t want;
  } dir_row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  bfm_pkg::in_t  in_item;
  logic          out_valid;
  bfm_pkg::out_t out_item;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [7:0]    cfg_index;
  logic [31:0]   cfg_data;

  // Predictor state.
  bit          filter_bits [STORE_BITS];
  logic [63:0] fnv_acc;
  logic [16:0] set_count;
  logic [4:0]  probes_reg;
  logic [16:0] span_reg;

  bfm_pkg::out_t pending_results[$];
  int          mismatches;
  int          cycles;
  int          burst_left;
  logic [7:0]  saved_keys [64][6];
  int          saved_len  [64];
  int          saved_n;

  bloom_filter_membership_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the result an accepted item causes and advances the state.
  task automatic bloom_step(input bfm_pkg::in_t it, output bit has_res,
                            output bfm_pkg::out_t res);
    logic [31:0] h1;
    logic [31:0] h2;
    logic [63:0] modulus;
    logic [63:0] pos;
    int          n;
    bit          all_set;
    has_res = 1'b0;
    res = '0;
    all_set = 1'b1;
    if (it.func == bfm_pkg::FUNC_NONE) return;
    if (it.func == bfm_pkg::FUNC_CLEAR) begin
      foreach (filter_bits[k]) filter_bits[k] = 1'b0;
      set_count = '0;
      fnv_acc = bfm_pkg::FNV_BASIS;
      has_res = 1'b1;
      res.done_kind = bfm_pkg::FUNC_CLEAR;
      return;
    end
    if (it.has_byte) fnv_acc = (fnv_acc ^ {56'd0, it.key_byte}) * FNV_MULT;
    if (!it.last) return;
    h1 = fnv_acc[31:0];
    h2 = fnv_acc[63:32];
    if (h2 == 32'd0) h2 = bfm_pkg::GOLDEN_STEP;
    fnv_acc = bfm_pkg::FNV_BASIS;
    n = (probes_reg == 0) ? 1 : (probes_reg > PROBE_MAX) ? PROBE_MAX : int'(probes_reg);
    modulus = (span_reg == 0) ? 64'd1 : (span_reg > STORE_BITS) ? 64'(STORE_BITS)
                                                                 : 64'(span_reg);
    for (int i = 0; i < n; i++) begin
      pos = ({32'd0, h1} + 64'(i) * {32'd0, h2}) % modulus;
      if (it.func == bfm_pkg::FUNC_ADD) begin
        if (!filter_bits[pos]) begin
          filter_bits[pos] = 1'b1;
          set_count = set_count + 17'd1;
        end
      end else if (!filter_bits[pos]) begin
        all_set = 1'b0;
      end
    end
    has_res = 1'b1;
    res.maybe_present = (it.func == bfm_pkg::FUNC_QUERY) ? all_set : 1'b0;
    res.set_bits = set_count;
    res.done_kind = it.func;
  endtask

  // Drives one item until the block takes it; the sender sometimes pauses between bursts.
  task automatic send_item(input bfm_pkg::in_t it, input bit typed = 1'b0,
                           input bfm_pkg::out_t want = '0);
    bit            has_res;
    bfm_pkg::out_t res;
    int            gap;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    bloom_step(it, has_res, res);
    if (typed) pending_results.push_back(want);
    else if (has_res) pending_results.push_back(res);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bfm_pkg::REG_PROBE_COUNT) probes_reg = data[4:0];
    else if (idx == bfm_pkg::REG_ACTIVE_BITS) span_reg = data[16:0];
  endtask

  // Sends one whole key.
  task automatic send_key(input logic [1:0] op, input int slot);
    bfm_pkg::in_t it;
    int           len;
    bit           reuse;
    reuse = (op == bfm_pkg::FUNC_QUERY) && (saved_n > 0) && ($urandom_range(0, 1) == 1);
    if (reuse) slot = $urandom_range(0, saved_n - 1);
    else len = $urandom_range(0, 6);
    if (reuse) len = saved_len[slot];
    for (int b = 0; b < len; b++) begin
      if (!reuse) saved_keys[slot][b] = 8'($urandom());
      it.func = (b == len - 1) ? op : 2'($urandom_range(0, 1));
      it.key_byte = saved_keys[slot][b];
      it.has_byte = 1'b1;
      it.last = (b == len - 1);
      send_item(it);
      // Occasional ignored item or skipped byte inside the key.
      if (b < len - 1 && $urandom_range(0, 15) == 0) begin
        it.func = ($urandom_range(0, 1) == 0) ? bfm_pkg::FUNC_NONE : bfm_pkg::FUNC_ADD;
        it.key_byte = 8'($urandom());
        it.has_byte = (it.func == bfm_pkg::FUNC_NONE) ? logic'($urandom_range(0, 1))
                                                      : 1'b0;
        it.last = (it.func == bfm_pkg::FUNC_NONE) ? logic'($urandom_range(0, 1)) : 1'b0;
        send_item(it);
      end
    end
    if (len == 0) begin
      it.func = op;
      it.key_byte = 8'($urandom());
      it.has_byte = 1'b0;
      it.last = 1'b1;
      send_item(it);
    end
    if (!reuse) saved_len[slot] = len;
    if (op == bfm_pkg::FUNC_ADD && !reuse && saved_n < 64 && slot == saved_n) saved_n++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        bfm_pkg::out_t want;
        want = pending_results.pop_front();
        if (out_item.maybe_present !== want.maybe_present ||
            out_item.set_bits !== want.set_bits ||
            out_item.done_kind !== want.done_kind) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows[$];
    dir_row_t    r;
    int          phase_items;
    int          clears_left;
    logic [4:0]  probe_set [8];
    logic [31:0] span_set  [8];

    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    mismatches = 0;
    cycles = 0;
    burst_left = 1;
    saved_n = 0;
    foreach (filter_bits[k]) filter_bits[k] = 1'b0;
    fnv_acc = bfm_pkg::FNV_BASIS;
    set_count = '0;
    probes_reg = bfm_pkg::PROBE_COUNT_RST;
    span_reg = bfm_pkg::ACTIVE_BITS_RST;

    // Directed items. Typed rows hold values evident from the behavior.
    r.typed = 1'b1; r.item = '{bfm_pkg::FUNC_QUERY, 8'h00, 1'b0, 1'b1};
    r.want = '{1'b0, 17'd0, bfm_pkg::FUNC_QUERY};
    rows.push_back(r);
    r.typed = 1'b0; r.want = '0;
    r.item = '{bfm_pkg::FUNC_ADD,   8'h00, 1'b0, 1'b1}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_QUERY, 8'hA5, 1'b0, 1'b1}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_QUERY, 8'h00, 1'b1, 1'b0}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_QUERY, 8'hFF, 1'b1, 1'b0}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_ADD,   8'h80, 1'b1, 1'b1}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_ADD,   8'h00, 1'b1, 1'b0}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_NONE,  8'h11, 1'b1, 1'b1}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_ADD,   8'hFF, 1'b1, 1'b0}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_ADD,   8'h33, 1'b0, 1'b0}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_QUERY, 8'h80, 1'b1, 1'b1}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_ADD,   8'h7F, 1'b1, 1'b1}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_QUERY, 8'h7F, 1'b1, 1'b1}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_NONE,  8'h00, 1'b0, 1'b0}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_ADD,   8'h42, 1'b1, 1'b0}; rows.push_back(r);
    // A clear mid-key drops the partial key.
    r.typed = 1'b1; r.item = '{bfm_pkg::FUNC_CLEAR, 8'hC3, 1'b1, 1'b0};
    r.want = '{1'b0, 17'd0, bfm_pkg::FUNC_CLEAR};
    rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_QUERY, 8'h7F, 1'b1, 1'b1};
    r.want = '{1'b0, 17'd0, bfm_pkg::FUNC_QUERY};
    rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_CLEAR, 8'h3C, 1'b0, 1'b1};
    r.want = '{1'b0, 17'd0, bfm_pkg::FUNC_CLEAR};
    rows.push_back(r);
    r.typed = 1'b0; r.want = '0;
    r.item = '{bfm_pkg::FUNC_ADD,   8'h01, 1'b1, 1'b1}; rows.push_back(r);
    r.item = '{bfm_pkg::FUNC_QUERY, 8'h01, 1'b1, 1'b1}; rows.push_back(r);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (busy);

    foreach (rows[k]) send_item(rows[k].item, rows[k].typed, rows[k].want);
    wait_idle();

    // Register settings per phase, extremes and out-of-range values included.
    probe_set = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd16, 5'd2, 5'd4};
    span_set  = '{32'd8, 32'd1000, 32'hFFFE_0000, 32'h0001_FFFF,
                  32'd65536, 32'd1, 32'hAAAA_5555, 32'd300};
    clears_left = 3;
    for (int p = 0; p < 8; p++) begin
      write_reg(bfm_pkg::REG_PROBE_COUNT,
                {$urandom_range(0, 1) ? 27'h7FF_FFFF : 27'd0, probe_set[p]});
      write_reg(bfm_pkg::REG_ACTIVE_BITS, span_set[p]);
      write_reg(8'd2 + 8'($urandom_range(0, 253)), $urandom());
      if (clears_left > 0 && (p % 3) == 1) begin
        send_item('{bfm_pkg::FUNC_CLEAR, 8'($urandom()), logic'($urandom_range(0, 1)),
                    logic'($urandom_range(0, 1))});
        clears_left--;
        saved_n = 0;
      end
      phase_items = 0;
      while (phase_items < 65) begin
        if ($urandom_range(0, 2) == 0) send_key(bfm_pkg::FUNC_ADD,
                                                (saved_n < 64) ? saved_n
                                                               : $urandom_range(0, 63));
        else send_key(bfm_pkg::FUNC_QUERY, 0);
        phase_items++;
      end
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
design/bfm_pkg.sv
design/bfm_mod_unit.sv
design/bloom_filter_membership_top.sv
design/bfm_checker.sv
test/tb.sv
